FILE: hw/rtl/dbi_pkg.sv
// dbi_pkg: shared types and constants of the director interpolator
// no dependencies

package dbi_pkg;

  // magnitudes are scaled down until all stay below 2^MAG_LIMIT_BIT
  localparam int MAG_LIMIT_BIT = 30;
  localparam int MAG_BITS      = 30;
  localparam int NSQ_BITS      = 64;
  localparam int NORM_BITS     = 32;

  // back end sequencer, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SHIFT = 7'b0000010,
    ST_SQ    = 7'b0000100,
    ST_SQRT  = 7'b0001000,
    ST_DLOAD = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_FIN   = 7'b1000000
  } back_state_t;

  // job handoff control from front end queue to back end
  typedef struct packed {
    logic valid;
  } job_ctl_t;

endpackage

FILE: hw/rtl/dbi_front.sv
// dbi_front: corner intake, sign alignment, weighting, accumulation, job queue
// depends on dbi_pkg

module dbi_front #(
  parameter int CB = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [CB-1:0]      dir_x,
  input  logic signed [CB-1:0]      dir_y,
  input  logic signed [CB-1:0]      dir_z,
  input  logic signed [CB-1:0]      corner_weight,
  input  logic                      point_found,
  input  logic                      last_corner,
  input  logic                      job_take,
  output dbi_pkg::job_ctl_t         job_ctl_o,
  output logic [3*((2*CB+2 > 64) ? 64 : 2*CB+2):0] job_data
);

  localparam int ACC = (2*CB+2 > 64) ? 64 : 2*CB+2;
  localparam int PW  = 2*CB+1;
  localparam int EW  = PW + ACC;
  localparam int JW  = 3*ACC + 1;

  // product stage
  logic                 p_valid;
  logic signed [PW-1:0] p_x, p_y, p_z;
  logic                 p_found, p_last;

  // accumulators
  logic [ACC-1:0] sx, sy, sz;
  logic           missing;

  // two entry job queue
  logic [JW-1:0] q_mem [2];
  logic          wr_ptr, rd_ptr;
  logic [1:0]    q_count;
  logic          q_full, q_push, q_pop;

  logic                 advance;
  logic                 accept;
  logic                 neg;
  logic signed [CB:0]   ax, ay, az, aw;
  logic signed [EW-1:0] ex, ey, ez;
  logic [ACC-1:0]       sx_next, sy_next, sz_next;
  logic                 missing_next;

  assign q_full   = (q_count == 2'd2);
  assign advance  = !(p_valid && p_last && q_full);
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign q_push   = p_valid && p_last && !q_full;
  assign q_pop    = job_take && (q_count != 2'd0);

  // align director with +y and widen for the negation of the most negative code
  always_comb begin
    neg = dir_y[CB-1];
    ax  = neg ? -(CB+1)'(dir_x) : (CB+1)'(dir_x);
    ay  = neg ? -(CB+1)'(dir_y) : (CB+1)'(dir_y);
    az  = neg ? -(CB+1)'(dir_z) : (CB+1)'(dir_z);
    aw  = (CB+1)'(corner_weight);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (advance) begin
      p_valid <= in_valid;
    end
    if (accept) begin
      p_x     <= PW'(ax * aw);
      p_y     <= PW'(ay * aw);
      p_z     <= PW'(az * aw);
      p_found <= point_found;
      p_last  <= last_corner;
    end
  end

  // accumulate, wrapping in ACC bits
  always_comb begin
    ex           = EW'(p_x);
    ey           = EW'(p_y);
    ez           = EW'(p_z);
    sx_next      = sx + ex[ACC-1:0];
    sy_next      = sy + ey[ACC-1:0];
    sz_next      = sz + ez[ACC-1:0];
    missing_next = missing || !p_found;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sx      <= '0;
      sy      <= '0;
      sz      <= '0;
      missing <= 1'b0;
    end else if (p_valid && advance) begin
      if (p_last) begin
        sx      <= '0;
        sy      <= '0;
        sz      <= '0;
        missing <= 1'b0;
      end else begin
        sx      <= sx_next;
        sy      <= sy_next;
        sz      <= sz_next;
        missing <= missing_next;
      end
    end
  end

  // job queue
  always_ff @(posedge clk) begin
    if (q_push) begin
      q_mem[wr_ptr] <= {missing_next, sz_next, sy_next, sx_next};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= 1'b0;
      rd_ptr  <= 1'b0;
      q_count <= 2'd0;
    end else begin
      if (q_push) wr_ptr <= !wr_ptr;
      if (q_pop)  rd_ptr <= !rd_ptr;
      q_count <= q_count + 2'(q_push) - 2'(q_pop);
    end
  end

  assign job_ctl_o.valid = (q_count != 2'd0);
  assign job_data        = q_mem[rd_ptr];

endmodule

FILE: hw/rtl/dbi_back.sv
// dbi_back: normalization of one accumulated vector per job
// depends on dbi_pkg

module dbi_back #(
  parameter int CB = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  dbi_pkg::job_ctl_t      job_ctl_i,
  input  logic [3*((2*CB+2 > 64) ? 64 : 2*CB+2):0] job_data,
  output logic                   job_take,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [CB-1:0]   unit_x,
  output logic signed [CB-1:0]   unit_y,
  output logic signed [CB-1:0]   unit_z,
  output logic                   result_valid
);

  localparam int ACC = (2*CB+2 > 64) ? 64 : 2*CB+2;
  localparam int F   = CB - 2;
  localparam int NW  = dbi_pkg::MAG_BITS + 1 + F;
  localparam int CW  = $clog2(NW + 1);
  localparam int MB  = dbi_pkg::MAG_BITS;
  localparam int NB  = dbi_pkg::NORM_BITS;

  dbi_pkg::back_state_t state;

  logic [ACC-1:0] mx, my, mz;
  logic           sgx, sgy, sgz;
  logic           zero_res;
  logic [1:0]     idx;
  logic [dbi_pkg::NSQ_BITS-1:0] nacc, sn, sres, sbit;
  logic [NB-1:0]  norm;
  logic [NW-1:0]  num, quot;
  logic [NB-1:0]  rem;
  logic [CW-1:0]  cnt;
  logic signed [CB-1:0] rx, ry, rz;

  // job unpacking
  logic [ACC-1:0] jx, jy, jz;
  logic           jmiss;
  logic [ACC-1:0] amx, amy, amz;
  assign jx    = job_data[ACC-1:0];
  assign jy    = job_data[2*ACC-1:ACC];
  assign jz    = job_data[3*ACC-1:2*ACC];
  assign jmiss = job_data[3*ACC];
  assign amx   = jx[ACC-1] ? -jx : jx;
  assign amy   = jy[ACC-1] ? -jy : jy;
  assign amz   = jz[ACC-1] ? -jz : jz;

  assign job_take = (state == dbi_pkg::ST_IDLE) && job_ctl_i.valid;

  // shared datapath pieces
  logic                big;
  logic [ACC-1:0]      sel;
  logic [MB-1:0]       sel30;
  logic [2*MB-1:0]     sq;
  logic [dbi_pkg::NSQ_BITS-1:0] rb;
  logic [NB:0]         trial;
  logic                qbit;
  logic [NW-1:0]       quot_next;
  logic [CB-1:0]       qmag;
  logic                sgsel;
  logic signed [CB-1:0] qsigned;
  logic                out_free;

  always_comb begin
    big = ((mx >> dbi_pkg::MAG_LIMIT_BIT) != '0) || ((my >> dbi_pkg::MAG_LIMIT_BIT) != '0)
       || ((mz >> dbi_pkg::MAG_LIMIT_BIT) != '0);
    case (idx)
      2'd0:    begin sel = mx; sgsel = sgx; end
      2'd1:    begin sel = my; sgsel = sgy; end
      default: begin sel = mz; sgsel = sgz; end
    endcase
    sel30     = MB'(sel);
    sq        = sel30 * sel30;
    rb        = sres + sbit;
    trial     = {rem, num[NW-1]};
    qbit      = (trial >= {1'b0, norm});
    quot_next = {quot[NW-2:0], qbit};
    qmag      = CB'(quot_next);
    qsigned   = sgsel ? -qmag : qmag;
    out_free  = !out_valid || !out_stall;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbi_pkg::ST_IDLE;
    end else begin
      case (state)
        dbi_pkg::ST_IDLE: begin
          if (job_ctl_i.valid) begin
            mx       <= amx;
            my       <= amy;
            mz       <= amz;
            sgx      <= jx[ACC-1];
            sgy      <= jy[ACC-1];
            sgz      <= jz[ACC-1];
            zero_res <= jmiss || ((jx | jy | jz) == '0);
            rx       <= '0;
            ry       <= '0;
            rz       <= '0;
            if (jmiss || ((jx | jy | jz) == '0)) state <= dbi_pkg::ST_FIN;
            else                                 state <= dbi_pkg::ST_SHIFT;
          end
        end
        // scale down until all magnitudes sit below the limit
        dbi_pkg::ST_SHIFT: begin
          if (big) begin
            mx <= mx >> 1;
            my <= my >> 1;
            mz <= mz >> 1;
          end else begin
            idx   <= 2'd0;
            nacc  <= '0;
            state <= dbi_pkg::ST_SQ;
          end
        end
        // sum of squares, one component a cycle
        dbi_pkg::ST_SQ: begin
          nacc <= nacc + dbi_pkg::NSQ_BITS'(sq);
          if (idx == 2'd2) begin
            sn    <= nacc + dbi_pkg::NSQ_BITS'(sq);
            sres  <= '0;
            sbit  <= dbi_pkg::NSQ_BITS'(1) << 62;
            state <= dbi_pkg::ST_SQRT;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        // integer square root, two radicand bits a cycle
        dbi_pkg::ST_SQRT: begin
          if (sn >= rb) begin
            sn   <= sn - rb;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if ((sbit >> 2) == '0) begin
            norm  <= (sn >= rb) ? NB'((sres >> 1) + sbit) : NB'(sres >> 1);
            idx   <= 2'd0;
            state <= dbi_pkg::ST_DLOAD;
          end
        end
        // rounded numerator for the current component
        dbi_pkg::ST_DLOAD: begin
          num   <= (NW'(sel30) << F) + NW'(norm >> 1);
          quot  <= '0;
          rem   <= '0;
          cnt   <= CW'(NW);
          state <= dbi_pkg::ST_DIV;
        end
        // restoring division, one quotient bit a cycle
        dbi_pkg::ST_DIV: begin
          rem  <= qbit ? NB'(trial - {1'b0, norm}) : NB'(trial);
          num  <= num << 1;
          quot <= quot_next;
          cnt  <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            case (idx)
              2'd0:    rx <= qsigned;
              2'd1:    ry <= qsigned;
              default: rz <= qsigned;
            endcase
            if (idx == 2'd2) begin
              state <= dbi_pkg::ST_FIN;
            end else begin
              idx   <= idx + 2'd1;
              state <= dbi_pkg::ST_DLOAD;
            end
          end
        end
        dbi_pkg::ST_FIN: begin
          if (out_free) state <= dbi_pkg::ST_IDLE;
        end
        default: state <= dbi_pkg::ST_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == dbi_pkg::ST_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if ((state == dbi_pkg::ST_FIN) && out_free) begin
      unit_x       <= rx;
      unit_y       <= ry;
      unit_z       <= rz;
      result_valid <= !zero_res;
    end
  end

endmodule

FILE: hw/rtl/director_barycentric_interpolator_core.sv
// Director interpolator: corner items accumulate into a weighted, sign-aligned sum
// per grid point; the front end takes one corner beat per cycle and queues finished
// sums (two deep), the back end normalizes one sum at a time. Per grid point the back
// end runs k scaling shifts, a 32 step square root and three restoring divides at
// one bit a cycle. Corner beats stall only while the queue holds two finished points
// and a last corner waits to enter it; results leave through an output register.
// Depends on dbi_pkg, dbi_front, dbi_back.

module director_barycentric_interpolator_core #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COMPONENT_BITS-1:0] dir_x,
  input  logic signed [COMPONENT_BITS-1:0] dir_y,
  input  logic signed [COMPONENT_BITS-1:0] dir_z,
  input  logic signed [COMPONENT_BITS-1:0] corner_weight,
  input  logic                          point_found,
  input  logic                          last_corner,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COMPONENT_BITS-1:0] unit_x,
  output logic signed [COMPONENT_BITS-1:0] unit_y,
  output logic signed [COMPONENT_BITS-1:0] unit_z,
  output logic                          result_valid
);

  localparam int ACC = (2*COMPONENT_BITS+2 > 64) ? 64 : 2*COMPONENT_BITS+2;

  dbi_pkg::job_ctl_t job_ctl;
  logic              job_take;
  logic [3*ACC:0]    job_data;

  // accumulate and queue
  dbi_front #(.CB(COMPONENT_BITS)) u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .dir_x         (dir_x),
    .dir_y         (dir_y),
    .dir_z         (dir_z),
    .corner_weight (corner_weight),
    .point_found   (point_found),
    .last_corner   (last_corner),
    .job_take      (job_take),
    .job_ctl_o     (job_ctl),
    .job_data      (job_data)
  );

  // normalize
  dbi_back #(.CB(COMPONENT_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .job_ctl_i    (job_ctl),
    .job_data     (job_data),
    .job_take     (job_take),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .unit_x       (unit_x),
    .unit_y       (unit_y),
    .unit_z       (unit_z),
    .result_valid (result_valid)
  );

endmodule

FILE: verif/tb_top.sv
// tb_top: self-checking testbench for director_barycentric_interpolator_core
// drives corner beats, predicts normalized director sums, checks each result beat
// depends on dbi_pkg and the core rtl

module tb_top;

  localparam int CB        = 16;
  localparam int FRAC      = CB - 2;
  localparam int ACC_W     = 2 * CB + 2;
  localparam int WDOG_MAX  = 20000;
  localparam int DRAIN_CYC = 400;

  // idling phases
  typedef enum int {
    IDLE_NONE,
    IDLE_SEND,
    IDLE_RECV,
    IDLE_BOTH
  } idle_mode_t;

  typedef struct packed {
    logic signed [CB-1:0] ux;
    logic signed [CB-1:0] uy;
    logic signed [CB-1:0] uz;
    logic                 ok;
  } unit_vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [CB-1:0] dir_x = '0, dir_y = '0, dir_z = '0, corner_weight = '0;
  logic point_found = 1'b0;
  logic last_corner = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [CB-1:0] unit_x, unit_y, unit_z;
  logic result_valid;

  idle_mode_t idle_mode = IDLE_NONE;
  int errors = 0;
  int wdog = 0;
  unit_vec_t pending_units[$];

  // predictor state
  logic [ACC_W-1:0] acc_x = '0, acc_y = '0, acc_z = '0;
  logic             any_missing = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  director_barycentric_interpolator_core #(.COMPONENT_BITS(CB)) i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z), .corner_weight(corner_weight),
    .point_found(point_found), .last_corner(last_corner),
    .out_valid(out_valid), .out_stall(out_stall),
    .unit_x(unit_x), .unit_y(unit_y), .unit_z(unit_z), .result_valid(result_valid)
  );

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = '0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] acc_abs(input logic [ACC_W-1:0] v);
    logic [ACC_W-1:0] m;
    m = v[ACC_W-1] ? (~v + 1'b1) : v;
    return 64'(m);
  endfunction

  function automatic logic [CB-1:0] apply_sign(input logic [63:0] mag, input logic neg);
    logic [63:0] r;
    r = neg ? (~mag + 64'd1) : mag;
    return r[CB-1:0];
  endfunction

  // accumulate one corner, return 1 with the normalized vector on the last corner
  function automatic bit accumulate_corner(input logic signed [CB-1:0] dx,
      input logic signed [CB-1:0] dy, input logic signed [CB-1:0] dz,
      input logic signed [CB-1:0] w, input logic found, input logic last,
      output unit_vec_t uv);
    logic signed [ACC_W-1:0] sx, sy, sz, sw;
    logic [63:0] ax, ay, az, mx, nrm, half;
    int k;
    sx = ACC_W'(dx); sy = ACC_W'(dy); sz = ACC_W'(dz); sw = ACC_W'(w);
    if (dy < 0) begin
      sx = -sx; sy = -sy; sz = -sz;
    end
    acc_x = acc_x + ACC_W'(sx * sw);
    acc_y = acc_y + ACC_W'(sy * sw);
    acc_z = acc_z + ACC_W'(sz * sw);
    if (!found) any_missing = 1'b1;
    uv = '0;
    if (!last) return 1'b0;
    ax = acc_abs(acc_x); ay = acc_abs(acc_y); az = acc_abs(acc_z);
    mx = ax;
    if (ay > mx) mx = ay;
    if (az > mx) mx = az;
    if (!any_missing && mx != 0) begin
      k = 0;
      while ((mx >> k) >= (64'd1 << dbi_pkg::MAG_LIMIT_BIT)) k++;
      ax = ax >> k; ay = ay >> k; az = az >> k;
      nrm = int_sqrt(ax * ax + ay * ay + az * az);
      half = nrm >> 1;
      uv.ux = apply_sign(((ax << FRAC) + half) / nrm, acc_x[ACC_W-1]);
      uv.uy = apply_sign(((ay << FRAC) + half) / nrm, acc_y[ACC_W-1]);
      uv.uz = apply_sign(((az << FRAC) + half) / nrm, acc_z[ACC_W-1]);
      uv.ok = 1'b1;
    end
    acc_x = '0; acc_y = '0; acc_z = '0; any_missing = 1'b0;
    return 1'b1;
  endfunction

  function automatic bit send_gap();
    return (idle_mode == IDLE_SEND && $urandom_range(99) < 45) ||
           (idle_mode == IDLE_BOTH && $urandom_range(99) < 34);
  endfunction

  // send one corner beat and record its prediction
  task automatic send_corner(input logic signed [CB-1:0] dx, input logic signed [CB-1:0] dy,
      input logic signed [CB-1:0] dz, input logic signed [CB-1:0] w,
      input logic found, input logic last);
    unit_vec_t uv;
    // idle cycles drop valid so no beat repeats
    if (send_gap()) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while (send_gap()) @(posedge clk);
    end
    in_valid <= 1'b1;
    dir_x <= dx; dir_y <= dy; dir_z <= dz; corner_weight <= w;
    point_found <= found; last_corner <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (accumulate_corner(dx, dy, dz, w, found, last, uv)) pending_units = {pending_units, uv};
  endtask

  function automatic logic [CB-1:0] rand_comp();
    case ($urandom_range(5))
      0: return {1'b1, {(CB-1){1'b0}}};
      1: return {1'b0, {(CB-1){1'b1}}};
      2: return '0;
      3: return CB'(1 << FRAC);
      default: return CB'($urandom);
    endcase
  endfunction

  task automatic send_point(input int corners, input bit allow_missing);
    logic found;
    for (int c = 0; c < corners; c++) begin
      found = allow_missing ? ($urandom_range(9) != 0) : 1'b1;
      send_corner(rand_comp(), rand_comp(), rand_comp(), rand_comp(), found,
                  c == corners - 1);
    end
  endtask

  // directed: extremes, zero length, not found, zero y, odd corner counts
  task automatic test_directed();
    localparam logic signed [CB-1:0] ONE = CB'(1 << FRAC);
    localparam logic signed [CB-1:0] MAXV = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] MINV = {1'b1, {(CB-1){1'b0}}};
    localparam logic signed [CB-1:0] ZERO = CB'(0);
    send_corner(ONE, ZERO, ZERO, ONE, 1'b1, 1'b1);
    send_corner(ZERO, ZERO, ZERO, ONE, 1'b1, 1'b1);
    send_corner(ONE, ONE, ONE, ONE, 1'b0, 1'b1);
    send_corner(-ONE, ZERO, ONE, ONE, 1'b1, 1'b1);
    send_corner(ONE, -ONE, -ONE, ONE, 1'b1, 1'b1);
    send_corner(MINV, MINV, MINV, MINV, 1'b1, 1'b0);
    send_corner(MINV, MINV, MINV, MINV, 1'b1, 1'b0);
    send_corner(MAXV, MAXV, MAXV, MINV, 1'b1, 1'b0);
    send_corner(MINV, MAXV, MINV, MAXV, 1'b1, 1'b1);
    send_corner(ONE, ONE, ZERO, MAXV, 1'b1, 1'b0);
    send_corner(-ONE, -ONE, ZERO, MAXV, 1'b1, 1'b1);
    send_corner(CB'(1), ZERO, ZERO, CB'(1), 1'b1, 1'b1);
    send_corner(ZERO, CB'(1), -CB'(1), MINV, 1'b1, 1'b0);
    send_corner(ONE, CB'(3), -CB'(5), CB'(7), 1'b0, 1'b0);
    send_corner(ONE, ONE, ONE, ONE, 1'b1, 1'b1);
    for (int i = 0; i < 6; i++) send_corner(MINV, MINV, MAXV, MINV, 1'b1, i == 5);
  endtask

  task automatic test_random(input idle_mode_t mode, input int points);
    idle_mode = mode;
    for (int p = 0; p < points; p++) begin
      if ($urandom_range(9) < 8) send_point(4, 1);
      else send_point($urandom_range(1, 7), 1);
    end
  endtask

  // result checker with receiver stalls
  always @(posedge clk) begin
    unit_vec_t exp_uv;
    if (!rst && out_valid && !out_stall) begin
      if (pending_units.size() == 0) begin
        $display("%0t: unexpected result beat %h %h %h %b", $time,
                 unit_x, unit_y, unit_z, result_valid);
        errors++;
      end else begin
        exp_uv = pending_units.pop_front();
        if (unit_x !== exp_uv.ux || unit_y !== exp_uv.uy || unit_z !== exp_uv.uz ||
            result_valid !== exp_uv.ok) begin
          $display("%0t: mismatch expected %h %h %h %b actual %h %h %h %b", $time,
                   exp_uv.ux, exp_uv.uy, exp_uv.uz, exp_uv.ok,
                   unit_x, unit_y, unit_z, result_valid);
          errors++;
        end
      end
    end
    if ((idle_mode == IDLE_RECV && $urandom_range(99) < 45) ||
        (idle_mode == IDLE_BOTH && $urandom_range(99) < 34)) out_stall <= 1'b1;
    else out_stall <= 1'b0;
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random(IDLE_NONE, 100);
    test_random(IDLE_SEND, 100);
    test_random(IDLE_RECV, 100);
    test_random(IDLE_BOTH, 100);
    test_random(IDLE_NONE, 8);
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    idle_mode = IDLE_NONE;
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
